// ===== rtl/sbsg_pkg.sv =====
// Shared constants and types for the strided box segment generator.
`default_nettype none

package sbsg_pkg;

    localparam int FIELD_DIMS = 4;
    localparam int RANK_W     = 3;
    localparam int ELEM_W     = 9;
    localparam int STRIDE_W   = 32;
    localparam int LEN_W      = 25;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int MAX_RANK_DEF   = 4;
    localparam int ADDR_BITS_DEF  = 48;
    localparam int INDEX_BITS_DEF = 16;

    localparam logic [ELEM_W-1:0] ELEM_MAX = 9'd256;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_NEXT  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_BOX     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_BOUNDS = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RANK     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ELEM     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_0 = 3'd2;

    typedef struct packed {
        logic capture;
        logic load_step;
        logic setup;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic load_done;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/sbsg_ctrl.sv =====
// Sequencer: request handshake, start/next flow and output register valid.
`default_nettype none

module sbsg_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  action,
    input  wire logic                  out_ready,
    output logic                       in_ready,
    output logic                       out_valid,
    output sbsg_pkg::ctrl_cmd_t        cmd,
    input  wire sbsg_pkg::dp_sts_t     sts
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOAD  = 2'd1;
    localparam logic [1:0] S_SETUP = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       slot_free;

    always_comb
    begin
        in_ready       = (state_reg == S_IDLE);
        accept         = in_valid & in_ready;
        slot_free      = !out_valid_reg | out_ready;
        cmd            = '0;
        cmd.capture    = accept;
        state_next     = state_reg;
        out_valid_next = out_valid_reg & !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (action == sbsg_pkg::ACT_NEXT) ? S_EMIT : S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load_step = 1'b1;
                if (sts.load_done)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold the result until the output register has room
                if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/sbsg_datapath.sv =====
// Datapath: config registers, offset multiply-accumulate, odometer walk, result register.
`default_nettype none

module sbsg_datapath #(
    parameter int MAX_RANK   = sbsg_pkg::MAX_RANK_DEF,
    parameter int ADDR_BITS  = sbsg_pkg::ADDR_BITS_DEF,
    parameter int INDEX_BITS = sbsg_pkg::INDEX_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire sbsg_pkg::ctrl_cmd_t               cmd,
    output sbsg_pkg::dp_sts_t                      sts,
    input  wire logic                              cfg_wr_en,
    input  wire logic [sbsg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sbsg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              action,
    input  wire logic [ADDR_BITS-1:0]              base_addr,
    input  wire logic [INDEX_BITS-1:0]             first_in [sbsg_pkg::FIELD_DIMS],
    input  wire logic [INDEX_BITS-1:0]             final_in [sbsg_pkg::FIELD_DIMS],
    output logic [ADDR_BITS-1:0]                   seg_addr,
    output logic [sbsg_pkg::LEN_W-1:0]             seg_bytes,
    output logic                                   last_segment,
    output logic [sbsg_pkg::STATUS_W-1:0]          status
);

    localparam int DIMS      = (MAX_RANK < sbsg_pkg::FIELD_DIMS) ? MAX_RANK : sbsg_pkg::FIELD_DIMS;
    localparam int LOAD_LAST = DIMS + 1;
    localparam int IDX_W     = $clog2(DIMS + 2);
    localparam int SP_W      = sbsg_pkg::ELEM_W + sbsg_pkg::STRIDE_W;
    localparam int STEP_W    = (ADDR_BITS < SP_W) ? ADDR_BITS : SP_W;
    localparam int MP_W      = (STEP_W + INDEX_BITS > ADDR_BITS) ? STEP_W + INDEX_BITS : ADDR_BITS;
    localparam int EXT_W     = INDEX_BITS + 1;
    localparam int LP_W      = (EXT_W + sbsg_pkg::ELEM_W > sbsg_pkg::LEN_W) ?
                               EXT_W + sbsg_pkg::ELEM_W : sbsg_pkg::LEN_W + 1;
    localparam int RW        = sbsg_pkg::RANK_W;

    // configuration
    logic [RW-1:0]                     rank_cfg_reg;
    logic [sbsg_pkg::ELEM_W-1:0]       elem_cfg_reg;
    logic [sbsg_pkg::STRIDE_W-1:0]     stride_cfg_reg [DIMS];
    logic [RW-1:0]                     rank_eff;
    logic [sbsg_pkg::ELEM_W-1:0]       el_eff;

    // captured request
    logic                              action_q_reg;
    logic [ADDR_BITS-1:0]              base_q_reg;
    logic [INDEX_BITS-1:0]             first_q_reg [DIMS];
    logic [INDEX_BITS-1:0]             fin_q_reg [DIMS];

    // offset pipeline
    logic [IDX_W-1:0]                  idx_reg;
    logic [STEP_W-1:0]                 step_reg [DIMS];
    logic [STEP_W-1:0]                 mul_a_reg;
    logic [ADDR_BITS-1:0]              prod_reg;
    logic [ADDR_BITS-1:0]              acc_reg;
    logic                              stage1;
    logic                              stage2;
    logic                              stage3;
    logic [sbsg_pkg::STRIDE_W-1:0]     stride_sel;
    logic [INDEX_BITS-1:0]             first_sel;
    logic [SP_W-1:0]                   sp;
    logic [STEP_W-1:0]                 step_val;
    logic [MP_W-1:0]                   pp;

    // box walk
    logic [ADDR_BITS-1:0]              row_start_reg [DIMS];
    logic [ADDR_BITS-1:0]              row_start_next [DIMS];
    logic [INDEX_BITS-1:0]             cnt_reg [DIMS];
    logic [INDEX_BITS-1:0]             cnt_next [DIMS];
    logic [EXT_W-1:0]                  ext_reg [DIMS];
    logic [EXT_W-1:0]                  ext_next [DIMS];
    logic [ADDR_BITS-1:0]              current_reg;
    logic [ADDR_BITS-1:0]              current_next;
    logic [sbsg_pkg::LEN_W-1:0]        seg_len_reg;
    logic [sbsg_pkg::LEN_W-1:0]        seg_len_next;
    logic [RW-1:0]                     lrank_reg;
    logic [RW-1:0]                     lrank_next;
    logic                              active_reg;
    logic                              active_next;

    // setup and advance helpers
    logic                              bad;
    logic [EXT_W-1:0]                  ext_last;
    logic [ADDR_BITS-1:0]              base_val;
    logic [LP_W-1:0]                   lp;
    logic [sbsg_pkg::LEN_W-1:0]        len_sat;
    logic [DIMS-1:0]                   more;
    logic [DIMS-1:0]                   sel_hot;
    logic                              last;
    logic                              seen;
    logic [ADDR_BITS-1:0]              sel_row;
    logic [STEP_W-1:0]                 sel_step;
    logic [ADDR_BITS-1:0]              new_addr;

    // result register
    logic [ADDR_BITS-1:0]              out_addr_reg;
    logic [ADDR_BITS-1:0]              out_addr_next;
    logic [sbsg_pkg::LEN_W-1:0]        out_bytes_reg;
    logic [sbsg_pkg::LEN_W-1:0]        out_bytes_next;
    logic                              out_last_reg;
    logic                              out_last_next;
    logic [sbsg_pkg::STATUS_W-1:0]     out_status_reg;
    logic [sbsg_pkg::STATUS_W-1:0]     out_status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_cfg_reg <= RW'(1);
            elem_cfg_reg <= sbsg_pkg::ELEM_W'(1);
            for (int d = 0; d < DIMS; d++)
            begin
                stride_cfg_reg[d] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == sbsg_pkg::REG_RANK)
            begin
                rank_cfg_reg <= cfg_data[RW-1:0];
            end
            if (cfg_index == sbsg_pkg::REG_ELEM)
            begin
                elem_cfg_reg <= cfg_data[sbsg_pkg::ELEM_W-1:0];
            end
            for (int d = 0; d < DIMS; d++)
            begin
                if (cfg_index == sbsg_pkg::REG_STRIDE_0 + sbsg_pkg::CFG_IDX_W'(d))
                begin
                    stride_cfg_reg[d] <= cfg_data[sbsg_pkg::STRIDE_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        if (rank_cfg_reg == '0)
        begin
            rank_eff = RW'(1);
        end
        else if (rank_cfg_reg > RW'(DIMS))
        begin
            rank_eff = RW'(DIMS);
        end
        else
        begin
            rank_eff = rank_cfg_reg;
        end
        el_eff = (elem_cfg_reg > sbsg_pkg::ELEM_MAX) ? sbsg_pkg::ELEM_MAX : elem_cfg_reg;
    end

    // Offset pipeline: one dimension enters per cycle; step = el*stride, then
    // step*first, then accumulate. Dimensions past the rank carry a zero step.
    always_comb
    begin
        stage1     = idx_reg < IDX_W'(DIMS);
        stage2     = (idx_reg != '0) && (idx_reg <= IDX_W'(DIMS));
        stage3     = idx_reg >= IDX_W'(2);
        stride_sel = '0;
        first_sel  = '0;
        for (int d = 0; d < DIMS; d++)
        begin
            if (idx_reg == IDX_W'(d))
            begin
                stride_sel = stride_cfg_reg[d];
            end
            if (idx_reg == IDX_W'(d + 1))
            begin
                first_sel = first_q_reg[d];
            end
        end
        sp       = SP_W'(el_eff) * SP_W'(stride_sel);
        step_val = (RW'(idx_reg) < rank_eff) ? sp[STEP_W-1:0] : '0;
        pp       = MP_W'(mul_a_reg) * MP_W'(first_sel);
        sts.load_done = (idx_reg == IDX_W'(LOAD_LAST));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.capture)
        begin
            idx_reg <= '0;
        end
        else if (cmd.load_step)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_q_reg <= action;
            base_q_reg   <= base_addr;
            acc_reg      <= '0;
            for (int d = 0; d < DIMS; d++)
            begin
                first_q_reg[d] <= first_in[d];
                fin_q_reg[d]   <= final_in[d];
            end
        end
        else if (cmd.load_step)
        begin
            if (stage1)
            begin
                mul_a_reg <= step_val;
                for (int d = 0; d < DIMS; d++)
                begin
                    if (idx_reg == IDX_W'(d))
                    begin
                        step_reg[d] <= step_val;
                    end
                end
            end
            if (stage2)
            begin
                prod_reg <= pp[ADDR_BITS-1:0];
            end
            if (stage3)
            begin
                acc_reg <= acc_reg + prod_reg;
            end
        end
    end

    // Box setup terms
    always_comb
    begin
        bad      = 1'b0;
        ext_last = '0;
        for (int d = 0; d < DIMS; d++)
        begin
            if (RW'(d) < rank_eff)
            begin
                if (fin_q_reg[d] < first_q_reg[d])
                begin
                    bad = 1'b1;
                end
            end
            if (RW'(d) == rank_eff - RW'(1))
            begin
                ext_last = EXT_W'(fin_q_reg[d]) - EXT_W'(first_q_reg[d]) + EXT_W'(1);
            end
        end
        base_val = base_q_reg + acc_reg;
        lp       = LP_W'(ext_last) * LP_W'(el_eff);
        len_sat  = (|lp[LP_W-1:sbsg_pkg::LEN_W]) ? '1 : lp[sbsg_pkg::LEN_W-1:0];
    end

    // Odometer: the innermost outer dimension that still has room advances,
    // every dimension inside it restarts from its new row address.
    always_comb
    begin
        for (int d = 0; d < DIMS; d++)
        begin
            more[d] = (RW'(d + 1) < lrank_reg) &&
                      (EXT_W'(cnt_reg[d]) + EXT_W'(1) < ext_reg[d]);
        end
        last     = ~|more;
        sel_hot  = '0;
        sel_row  = row_start_reg[0];
        sel_step = step_reg[0];
        for (int d = 0; d < DIMS; d++)
        begin
            if (more[d])
            begin
                sel_hot  = '0;
                sel_hot[d] = 1'b1;
                sel_row  = row_start_reg[d];
                sel_step = step_reg[d];
            end
        end
        new_addr = sel_row + ADDR_BITS'(sel_step);
    end

    always_comb
    begin
        row_start_next  = row_start_reg;
        cnt_next        = cnt_reg;
        ext_next        = ext_reg;
        current_next    = current_reg;
        seg_len_next    = seg_len_reg;
        lrank_next      = lrank_reg;
        active_next     = active_reg;
        out_addr_next   = out_addr_reg;
        out_bytes_next  = out_bytes_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        seen            = 1'b0;

        if (cmd.setup)
        begin
            for (int d = 0; d < DIMS; d++)
            begin
                row_start_next[d] = base_val;
                cnt_next[d]       = '0;
                if (RW'(d) < rank_eff)
                begin
                    ext_next[d] = EXT_W'(fin_q_reg[d]) - EXT_W'(first_q_reg[d]) + EXT_W'(1);
                end
                else
                begin
                    ext_next[d] = '0;
                end
            end
            current_next = base_val;
            seg_len_next = len_sat;
            lrank_next   = rank_eff;
            active_next  = !bad;
        end

        if (cmd.emit)
        begin
            if (active_reg)
            begin
                out_addr_next   = current_reg;
                out_bytes_next  = seg_len_reg;
                out_last_next   = last;
                out_status_next = sbsg_pkg::ST_OK;
                if (last)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    for (int d = 0; d < DIMS; d++)
                    begin
                        if (seen)
                        begin
                            cnt_next[d]       = '0;
                            row_start_next[d] = new_addr;
                        end
                        if (sel_hot[d])
                        begin
                            cnt_next[d]       = cnt_reg[d] + INDEX_BITS'(1);
                            row_start_next[d] = new_addr;
                            seen              = 1'b1;
                        end
                    end
                    current_next = new_addr;
                end
            end
            else
            begin
                out_addr_next   = '0;
                out_bytes_next  = '0;
                out_last_next   = 1'b0;
                out_status_next = (action_q_reg == sbsg_pkg::ACT_NEXT) ?
                                  sbsg_pkg::ST_NO_BOX : sbsg_pkg::ST_BAD_BOUNDS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            lrank_reg  <= RW'(1);
        end
        else
        begin
            active_reg <= active_next;
            lrank_reg  <= lrank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_start_reg  <= row_start_next;
        cnt_reg        <= cnt_next;
        ext_reg        <= ext_next;
        current_reg    <= current_next;
        seg_len_reg    <= seg_len_next;
        out_addr_reg   <= out_addr_next;
        out_bytes_reg  <= out_bytes_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign seg_addr     = out_addr_reg;
    assign seg_bytes    = out_bytes_reg;
    assign last_segment = out_last_reg;
    assign status       = out_status_reg;

endmodule

`default_nettype wire

// ===== rtl/strided_box_segment_generator_unit.sv =====
// A next request goes straight to the emit step; a start request first runs the offset
// multiply-accumulate, which takes one dimension per cycle through two registered
// multipliers, then the box setup, and then emits its first segment. Only one request is
// taken at a time, and the emit waits while the output register is full. Reset is
// asynchronous, active low: rank 1, element size 1, strides 0, no box active, output
// register empty.
`default_nettype none

module strided_box_segment_generator_unit #(
    parameter int MAX_RANK   = sbsg_pkg::MAX_RANK_DEF,
    parameter int ADDR_BITS  = sbsg_pkg::ADDR_BITS_DEF,
    parameter int INDEX_BITS = sbsg_pkg::INDEX_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [sbsg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sbsg_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              action,
    input  wire logic [ADDR_BITS-1:0]              base_addr,
    input  wire logic [INDEX_BITS-1:0]             first_0,
    input  wire logic [INDEX_BITS-1:0]             first_1,
    input  wire logic [INDEX_BITS-1:0]             first_2,
    input  wire logic [INDEX_BITS-1:0]             first_3,
    input  wire logic [INDEX_BITS-1:0]             final_0,
    input  wire logic [INDEX_BITS-1:0]             final_1,
    input  wire logic [INDEX_BITS-1:0]             final_2,
    input  wire logic [INDEX_BITS-1:0]             final_3,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [ADDR_BITS-1:0]                   seg_addr,
    output logic [sbsg_pkg::LEN_W-1:0]             seg_bytes,
    output logic                                   last_segment,
    output logic [sbsg_pkg::STATUS_W-1:0]          status
);

    sbsg_pkg::ctrl_cmd_t cmd;
    sbsg_pkg::dp_sts_t   sts;
    logic [INDEX_BITS-1:0] first_arr [sbsg_pkg::FIELD_DIMS];
    logic [INDEX_BITS-1:0] final_arr [sbsg_pkg::FIELD_DIMS];

    assign first_arr[0] = first_0;
    assign first_arr[1] = first_1;
    assign first_arr[2] = first_2;
    assign first_arr[3] = first_3;
    assign final_arr[0] = final_0;
    assign final_arr[1] = final_1;
    assign final_arr[2] = final_2;
    assign final_arr[3] = final_3;

    sbsg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .action    (action),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd),
        .sts       (sts)
    );

    sbsg_datapath #(
        .MAX_RANK   (MAX_RANK),
        .ADDR_BITS  (ADDR_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .action       (action),
        .base_addr    (base_addr),
        .first_in     (first_arr),
        .final_in     (final_arr),
        .seg_addr     (seg_addr),
        .seg_bytes    (seg_bytes),
        .last_segment (last_segment),
        .status       (status)
    );

endmodule

`default_nettype wire

// ===== rtl/sbsg_checker.sv =====
// Port-level checks for the segment generator, bound to the top level.
`default_nettype none

module sbsg_checker #(
    parameter int ADDR_BITS = sbsg_pkg::ADDR_BITS_DEF
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [ADDR_BITS-1:0]          seg_addr,
    input wire logic [sbsg_pkg::LEN_W-1:0]    seg_bytes,
    input wire logic                          last_segment,
    input wire logic [sbsg_pkg::STATUS_W-1:0] status
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(seg_addr) && $stable(seg_bytes)
                                    && $stable(last_segment) && $stable(status))
        else $error("result changed while stalled");

    // error results carry no segment
    a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != sbsg_pkg::ST_OK |->
            seg_addr == '0 && seg_bytes == '0 && !last_segment)
        else $error("error result with segment data");

    // one request in flight at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");

    // a fresh result only follows a busy cycle
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a request");

endmodule

bind strided_box_segment_generator_unit sbsg_checker #(.ADDR_BITS(ADDR_BITS)) u_sbsg_checker (.*);

`default_nettype wire
